/* rtl/assert_macros.svh */
// Assertion macros shared by the RTL files that check themselves
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property at every rising clock edge, skipped while reset is high
`define SFD_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Check a property at every rising clock edge, reset included
`define SFD_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* rtl/sfd_pkg.sv */
// Shared types and constants of the serial frame deframer
package sfd_pkg;

  localparam int unsigned ByteW   = 8;
  localparam int unsigned SumW    = 16;
  localparam int unsigned StatusW = 2;
  localparam int unsigned TdataW  = 56;

  // Frame status codes
  localparam logic [StatusW-1:0] ST_GOOD     = 2'd0;
  localparam logic [StatusW-1:0] ST_MISMATCH = 2'd1;
  localparam logic [StatusW-1:0] ST_LEN_ERR  = 2'd2;

  // Result kinds
  localparam logic KIND_PAYLOAD = 1'b0;
  localparam logic KIND_END     = 1'b1;

  // Configuration register indexes
  localparam logic CFG_SYNC_FIRST  = 1'b0;
  localparam logic CFG_SYNC_SECOND = 1'b1;

  // Register reset values and frame constants
  localparam logic [ByteW-1:0] SYNC_FIRST_RST  = 8'h55;
  localparam logic [ByteW-1:0] SYNC_SECOND_RST = 8'hAA;
  localparam logic [ByteW-1:0] MIN_LEN         = 8'd2;
  localparam logic [ByteW-1:0] HDR_BYTES       = 8'd3;
  localparam logic [SumW-1:0]  SUM_INVERT      = 16'hFFFF;

  // Parser phases
  typedef enum logic [5:0] {
    PH_HUNT1 = 6'b000001,
    PH_HUNT2 = 6'b000010,
    PH_LEN   = 6'b000100,
    PH_BODY  = 6'b001000,
    PH_CKLO  = 6'b010000,
    PH_CKHI  = 6'b100000
  } sfd_phase_t;

  // Registered input item
  typedef struct packed {
    logic             valid;
    logic [ByteW-1:0] rx_byte;
  } sfd_in_t;

  // One result item
  typedef struct packed {
    logic               kind;
    logic [ByteW-1:0]   data_byte;
    logic [ByteW-1:0]   byte_index;
    logic [ByteW-1:0]   source;
    logic [ByteW-1:0]   command;
    logic [ByteW-1:0]   argument;
    logic [ByteW-1:0]   payload_len;
    logic [StatusW-1:0] status;
    logic               last;
  } sfd_result_t;

endpackage

/* rtl/serial_frame_deframer_checksum_top.sv */
// Path: each accepted byte is captured in the input register, and its result then in the result register.
// Throughput: one byte per cycle; the parser commits one byte whenever the result register
// is empty or being read, so a stalled sink blocks the input once one byte waits behind it.
// Reset (rst, synchronous, active high): hunting for the first preamble byte, preamble
// registers back to 0x55 and 0xAA, both pipeline registers empty.
// Configuration writes are taken in any cycle.
`include "assert_macros.svh"

// Top level of the serial frame deframer with inverted 16-bit sum checksum
module serial_frame_deframer_checksum_top
  import sfd_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  // Input stream
  input  logic              s_tvalid,
  output logic              s_tready,
  input  logic [ByteW-1:0]  s_tdata,   // [7:0] rx_byte
  // Result stream
  output logic              m_tvalid,
  input  logic              m_tready,
  // [7:0] data_byte, [15:8] byte_index, [23:16] source, [31:24] command,
  // [39:32] argument, [47:40] payload_len, [49:48] status, [55:50] zero
  output logic [TdataW-1:0] m_tdata,
  output logic              m_tuser,   // [0] kind
  output logic              m_tlast,
  // Configuration writes
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic              cfg_index,
  input  logic [ByteW-1:0]  cfg_data
);

  logic [ByteW-1:0] sync_first;
  logic [ByteW-1:0] sync_second;
  sfd_in_t          in_q;
  logic             advance;
  logic             res_valid;
  sfd_result_t      res;
  sfd_result_t      out_q;

  // Preamble registers
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      sync_first  <= SYNC_FIRST_RST;
      sync_second <= SYNC_SECOND_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_SYNC_FIRST:  sync_first  <= cfg_data;
        CFG_SYNC_SECOND: sync_second <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  // Move the held byte through the parser when the result register is empty or being read
  assign advance = in_q.valid && (!m_tvalid || m_tready);

  sfd_in_reg u_in_reg (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .advance  (advance),
    .in_q     (in_q)
  );

  sfd_core u_core (
    .clk         (clk),
    .rst         (rst),
    .in_q        (in_q),
    .advance     (advance),
    .sync_first  (sync_first),
    .sync_second (sync_second),
    .res_valid   (res_valid),
    .res         (res)
  );

  sfd_out_reg u_out_reg (
    .clk       (clk),
    .rst       (rst),
    .advance   (advance),
    .res_valid (res_valid),
    .res       (res),
    .m_tready  (m_tready),
    .out_valid (m_tvalid),
    .out_q     (out_q)
  );

  // Pack the result item
  assign m_tdata = {6'd0, out_q.status, out_q.payload_len, out_q.argument,
                    out_q.command, out_q.source, out_q.byte_index, out_q.data_byte};
  assign m_tuser = out_q.kind;
  assign m_tlast = out_q.last;

  // End-of-frame results and only those carry tlast
  `SFD_ASSERT(a_last_on_end, m_tvalid |-> (m_tuser == m_tlast), "tlast does not match kind")
  // Payload results carry no status or header
  `SFD_ASSERT(a_payload_clean, (m_tvalid && !m_tuser) |-> (m_tdata[49:16] == 34'd0), "payload result has header bits")
  // A length error carries no header
  `SFD_ASSERT(a_len_err_clean, (m_tvalid && m_tuser && (m_tdata[49:48] == ST_LEN_ERR)) |-> (m_tdata[47:0] == 48'd0), "length error result has data")
  // A held byte that cannot move keeps its value
  `SFD_ASSERT(a_in_hold, (in_q.valid && !advance) |=> (in_q.valid && $stable(in_q.rx_byte)), "stalled input byte changed")

endmodule

/* rtl/sfd_in_reg.sv */
// Input register stage: captures each accepted byte
module sfd_in_reg
  import sfd_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             s_tvalid,
  output logic             s_tready,
  input  logic [ByteW-1:0] s_tdata,  // [7:0] rx_byte
  input  logic             advance,
  output sfd_in_t          in_q
);

  // Take a new item when empty or when the held one moves on this cycle
  assign s_tready = !in_q.valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_q.valid   <= 1'b0;
      in_q.rx_byte <= '0;
    end else if (s_tvalid && s_tready) begin
      in_q.valid   <= 1'b1;
      in_q.rx_byte <= s_tdata;
    end else if (advance) begin
      in_q.valid <= 1'b0;
    end
  end

endmodule

/* rtl/sfd_core.sv */
// Frame parser: phase tracking, header capture, checksum and result forming
module sfd_core
  import sfd_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  sfd_in_t          in_q,
  input  logic             advance,
  input  logic [ByteW-1:0] sync_first,
  input  logic [ByteW-1:0] sync_second,
  output logic             res_valid,
  output sfd_result_t      res
);

  sfd_phase_t       phase, phase_next;
  logic [ByteW-1:0] frame_length, frame_length_next;
  logic [ByteW-1:0] body_count, body_count_next;
  logic [SumW-1:0]  running_sum, running_sum_next;
  logic [ByteW-1:0] held_source, held_source_next;
  logic [ByteW-1:0] held_command, held_command_next;
  logic [ByteW-1:0] held_argument, held_argument_next;
  logic [ByteW-1:0] checksum_low, checksum_low_next;
  logic [ByteW-1:0] b;
  logic [SumW-1:0]  sum_add;
  logic [SumW-1:0]  got_sum;

  assign b       = in_q.rx_byte;
  assign sum_add = running_sum + {{(SumW-ByteW){1'b0}}, b};
  assign got_sum = {b, checksum_low};

  // Work out the next state and any result for the held byte
  always_comb begin
    phase_next         = phase;
    frame_length_next  = frame_length;
    body_count_next    = body_count;
    running_sum_next   = running_sum;
    held_source_next   = held_source;
    held_command_next  = held_command;
    held_argument_next = held_argument;
    checksum_low_next  = checksum_low;
    res_valid          = 1'b0;
    res                = '0;
    case (phase)
      PH_HUNT2: begin
        phase_next = (b == sync_second) ? PH_LEN : PH_HUNT1;
      end
      PH_LEN: begin
        if (b < MIN_LEN) begin
          // Short length ends the frame at once
          phase_next = PH_HUNT1;
          res_valid  = 1'b1;
          res.kind   = KIND_END;
          res.status = ST_LEN_ERR;
          res.last   = 1'b1;
        end else begin
          frame_length_next = b;
          body_count_next   = '0;
          running_sum_next  = {{(SumW-ByteW){1'b0}}, b};
          phase_next        = PH_BODY;
        end
      end
      PH_BODY: begin
        running_sum_next = sum_add;
        if (body_count == 8'd0) begin
          held_source_next = b;
        end else if (body_count == 8'd1) begin
          held_command_next = b;
        end else if (body_count == 8'd2) begin
          held_argument_next = b;
        end else begin
          res_valid      = 1'b1;
          res.kind       = KIND_PAYLOAD;
          res.data_byte  = b;
          res.byte_index = body_count - HDR_BYTES;
        end
        if (body_count == frame_length) begin
          phase_next = PH_CKLO;
        end else begin
          body_count_next = body_count + 8'd1;
        end
      end
      PH_CKLO: begin
        checksum_low_next = b;
        phase_next        = PH_CKHI;
      end
      PH_CKHI: begin
        phase_next      = PH_HUNT1;
        res_valid       = 1'b1;
        res.kind        = KIND_END;
        res.source      = held_source;
        res.command     = held_command;
        res.argument    = held_argument;
        res.payload_len = frame_length - MIN_LEN;
        res.status      = (got_sum == (SUM_INVERT ^ running_sum)) ? ST_GOOD : ST_MISMATCH;
        res.last        = 1'b1;
      end
      default: begin
        // Hunt for the first preamble byte
        phase_next = (b == sync_first) ? PH_HUNT2 : PH_HUNT1;
      end
    endcase
  end

  // Commit the state when the held byte moves on
  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_HUNT1;
      frame_length  <= '0;
      body_count    <= '0;
      running_sum   <= '0;
      held_source   <= '0;
      held_command  <= '0;
      held_argument <= '0;
      checksum_low  <= '0;
    end else if (advance) begin
      phase         <= phase_next;
      frame_length  <= frame_length_next;
      body_count    <= body_count_next;
      running_sum   <= running_sum_next;
      held_source   <= held_source_next;
      held_command  <= held_command_next;
      held_argument <= held_argument_next;
      checksum_low  <= checksum_low_next;
    end
  end

endmodule

/* rtl/sfd_out_reg.sv */
// Result register: holds one result item until the sink takes it
module sfd_out_reg
  import sfd_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        advance,
  input  logic        res_valid,
  input  sfd_result_t res,
  input  logic        m_tready,
  output logic        out_valid,
  output sfd_result_t out_q
);

  // Load on advance, drop once taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= res_valid;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
  end

  // Payload needs no reset
  always_ff @(posedge clk) begin
    if (advance) begin
      out_q <= res;
    end
  end

endmodule
